/* hdl/pbrg_pkg.sv */
// shared types and constants of the probe and backoff rate governor
`timescale 1ns / 1ps
package pbrg_pkg;

  typedef enum logic [1:0] {
    PH_BASE  = 2'd0,
    PH_PROBE = 2'd1,
    PH_BACK  = 2'd2,
    PH_NONE  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_DECIDE,
    ST_OUT
  } ctl_state_t;

  localparam int unsigned MIN_SAMPLES = 30;
  localparam int unsigned MEASURE_MS  = 2000;
  localparam int unsigned POLL_MS     = 2000;
  localparam int unsigned DECAY_MS    = 1000;
  localparam int unsigned GAIN_NUM    = 294;
  localparam int unsigned FLOOR_NUM   = 179;
  localparam int          BLOCK_LEVEL = 4;
  localparam int          NOGROW_LEVEL = 3;

  // backoff wait by index, in ms
  function automatic logic [16:0] backoff_ms(input logic [1:0] idx);
    logic [16:0] v;
    begin
      unique case (idx)
        2'd0: v = 17'd5000;
        2'd1: v = 17'd15000;
        2'd2: v = 17'd30000;
        default: v = 17'd60000;
      endcase
      return v;
    end
  endfunction

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic div_start;
    logic decide;
    logic cfg_write;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_needed;
    logic div_done;
  } dp_sts_t;

endpackage

/* hdl/pbrg_divider.sv */
// serial restoring divider for two sums by a shared count
`timescale 1ns / 1ps
module pbrg_divider #(
  parameter int SUM_BITS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SUM_BITS-1:0]   num_a,
  input  logic [SUM_BITS-1:0]   num_b,
  input  logic [COUNT_BITS-1:0] den,
  output logic [SUM_BITS-1:0]   quo_a,
  output logic [SUM_BITS-1:0]   quo_b,
  output logic                  done
);
  localparam int CNT_W = $clog2(SUM_BITS + 1);

  logic [SUM_BITS-1:0]   qa_r, qb_r, qa_nxt, qb_nxt;
  logic [COUNT_BITS:0]   ra_r, rb_r, ra_nxt, rb_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt, done_r, done_nxt;
  logic [COUNT_BITS:0]   sa, sb;

  // one quotient bit a cycle for each sum
  always_comb begin
    qa_nxt = qa_r; qb_nxt = qb_r; ra_nxt = ra_r; rb_nxt = rb_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    sa = '0; sb = '0;
    if (start) begin
      qa_nxt = num_a; qb_nxt = num_b; ra_nxt = '0; rb_nxt = '0;
      cnt_nxt = CNT_W'(SUM_BITS); busy_nxt = 1'b1;
    end else if (busy_r) begin
      sa = {ra_r[COUNT_BITS-1:0], qa_r[SUM_BITS-1]};
      sb = {rb_r[COUNT_BITS-1:0], qb_r[SUM_BITS-1]};
      qa_nxt = {qa_r[SUM_BITS-2:0], 1'b0};
      qb_nxt = {qb_r[SUM_BITS-2:0], 1'b0};
      ra_nxt = sa; rb_nxt = sb;
      if (sa >= {1'b0, den}) begin
        ra_nxt = sa - {1'b0, den}; qa_nxt[0] = 1'b1;
      end
      if (sb >= {1'b0, den}) begin
        rb_nxt = sb - {1'b0, den}; qb_nxt[0] = 1'b1;
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    qa_r <= qa_nxt; qb_r <= qb_nxt; ra_r <= ra_nxt; rb_r <= rb_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign quo_a = qa_r;
  assign quo_b = qb_r;
  assign done  = done_r;
endmodule

/* hdl/pbrg_datapath.sv */
// governor state registers, sampling, phase decisions and result fields
`timescale 1ns / 1ps
module pbrg_datapath #(
  parameter int LEVEL_LIMIT = 8,
  parameter int RATE_BITS   = 16,
  parameter int TIME_BITS   = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pbrg_pkg::dp_cmd_t     cmd,
  output pbrg_pkg::dp_sts_t     sts,
  input  logic [3:0]            cfg_value,
  input  logic [3:0]            req_in,
  input  logic [RATE_BITS-1:0]  src_in,
  input  logic [RATE_BITS-1:0]  lp_in,
  input  logic [TIME_BITS-1:0]  now_in,
  input  logic [3:0]            ts_in,
  output logic [3:0]            allowed_o,
  output logic [1:0]            phase_o,
  output logic                  blocked_o,
  output logic [3:0]            accepted_o
);
  localparam int SUM_BITS = RATE_BITS + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [3:0] LIM = 4'(LEVEL_LIMIT);

  // item fields held for the whole transaction
  logic [3:0]           req_r;
  logic [RATE_BITS-1:0] src_r, lp_r;
  logic [TIME_BITS-1:0] now_r;
  logic [3:0]           ts_r;

  logic [3:0]            maxg_r, acc_r, allowed_r;
  pbrg_pkg::phase_t      phase_r;
  logic                  started_r, bvalid_r, poll_valid_r, decay_valid_r;
  logic [TIME_BITS-1:0]  pstart_r, lpoll_r, ldecay_r;
  logic [SUM_BITS-1:0]   ssum_r, lsum_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [RATE_BITS-1:0]  bsrc_r, blp_r;
  logic [1:0]            bidx_r;
  logic signed [3:0]     therm_r;
  logic                  divn_r;

  logic [SUM_BITS-1:0]   qa, qb;
  logic                  ddone;

  pbrg_divider #(.SUM_BITS(SUM_BITS), .COUNT_BITS(COUNT_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num_a(ssum_r), .num_b(lsum_r), .den(cnt_r),
    .quo_a(qa), .quo_b(qb), .done(ddone)
  );

  assign sts.div_needed = divn_r;
  assign sts.div_done   = ddone;

  logic [3:0] cap;
  assign cap = (maxg_r > LIM) ? LIM : maxg_r;

  // eval stage: thermal poll, decay, sampling; flags whether a division follows
  logic signed [3:0]    therm_new;
  logic                 poll_due, active;
  logic [TIME_BITS-1:0] el;
  logic                 blocked_new;
  logic                 smp;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                 meas_ok;
  always_comb begin
    active    = (cap != 4'd0) && (req_r != 4'd0);
    poll_due  = !poll_valid_r || ((now_r - lpoll_r) >= TIME_BITS'(pbrg_pkg::POLL_MS));
    therm_new = poll_due ? $signed(ts_r) : therm_r;
    blocked_new = therm_new >= 4'sd4;
    smp       = (src_r != '0) && (lp_r != '0) && (cnt_r != CMAX);
    cnt_new   = smp ? cnt_r + COUNT_BITS'(1) : cnt_r;
    el        = now_r - (started_r ? pstart_r : now_r);
    meas_ok   = (el >= TIME_BITS'(pbrg_pkg::MEASURE_MS))
                && (cnt_new >= COUNT_BITS'(pbrg_pkg::MIN_SAMPLES));
  end

  // decision stage products
  logic [RATE_BITS+8:0] pl_s, bl_g, ps_s, bs_f;
  logic improved, held, grow;
  always_comb begin
    pl_s = {qb[RATE_BITS:0], 8'd0};
    bl_g = (RATE_BITS+9)'(blp_r) * (RATE_BITS+9)'(pbrg_pkg::GAIN_NUM);
    ps_s = {qa[RATE_BITS:0], 8'd0};
    bs_f = (RATE_BITS+9)'(bsrc_r) * (RATE_BITS+9)'(pbrg_pkg::FLOOR_NUM);
    improved = (blp_r != '0) && ((|qb[SUM_BITS-1:RATE_BITS+1]) || pl_s >= bl_g);
    held = (bsrc_r == '0) || (|qa[SUM_BITS-1:RATE_BITS+1]) || ps_s >= bs_f;
    grow = (acc_r < cap) && (req_r > acc_r) && (therm_r < 4'sd3);
  end

  function automatic logic [3:0] min4(input logic [3:0] a, input logic [3:0] b);
    return (a < b) ? a : b;
  endfunction

  logic [3:0] allowed_calc, acc1;
  always_comb begin
    acc1 = min4(acc_r + 4'd1, cap);
    allowed_calc = (phase_r == pbrg_pkg::PH_PROBE) ? acc1 : acc_r;
    allowed_calc = min4(req_r, allowed_calc);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_in; src_r <= src_in; lp_r <= lp_in; now_r <= now_in; ts_r <= ts_in;
    end
    if (!rst_n) begin
      maxg_r <= '0; acc_r <= '0; phase_r <= pbrg_pkg::PH_BASE; started_r <= 1'b0;
      pstart_r <= '0; ssum_r <= '0; lsum_r <= '0; cnt_r <= '0;
      bsrc_r <= '0; blp_r <= '0; bvalid_r <= 1'b0; bidx_r <= '0;
      therm_r <= -4'sd1; poll_valid_r <= 1'b0; lpoll_r <= '0;
      decay_valid_r <= 1'b0; ldecay_r <= '0; divn_r <= 1'b0; allowed_r <= '0;
    end else if (cmd.cfg_write) begin
      // a changed ceiling clamps and restarts baseline
      if (cfg_value != maxg_r) begin
        maxg_r <= cfg_value;
        if (acc_r > ((cfg_value > LIM) ? LIM : cfg_value))
          acc_r <= (cfg_value > LIM) ? LIM : cfg_value;
        phase_r <= pbrg_pkg::PH_BASE; started_r <= 1'b0;
        ssum_r <= '0; lsum_r <= '0; cnt_r <= '0; bvalid_r <= 1'b0;
      end
    end else if (cmd.eval) begin
      divn_r <= 1'b0;
      allowed_r <= '0;
      if (active) begin
        if (!started_r) begin
          phase_r <= pbrg_pkg::PH_BASE; started_r <= 1'b1; pstart_r <= now_r;
        end
        if (poll_due) begin
          lpoll_r <= now_r; poll_valid_r <= 1'b1; therm_r <= therm_new;
        end
        if (blocked_new) begin
          if (acc_r != 4'd0
              && (!decay_valid_r || (now_r - ldecay_r) >= TIME_BITS'(pbrg_pkg::DECAY_MS))) begin
            acc_r <= acc_r - 4'd1; ldecay_r <= now_r; decay_valid_r <= 1'b1;
            phase_r <= pbrg_pkg::PH_BACK; started_r <= 1'b1; pstart_r <= now_r;
            ssum_r <= '0; lsum_r <= '0; cnt_r <= '0;
            if (bidx_r != 2'd3) bidx_r <= bidx_r + 2'd1;
            allowed_r <= min4(req_r, acc_r - 4'd1);
          end else begin
            allowed_r <= min4(req_r, acc_r);
          end
        end else begin
          decay_valid_r <= 1'b0;
          if (smp) begin
            ssum_r <= ssum_r + SUM_BITS'(src_r);
            lsum_r <= lsum_r + SUM_BITS'(lp_r);
            cnt_r  <= cnt_new;
          end
          if (!started_r) begin
            // fresh baseline just started: elapsed is zero
            divn_r <= 1'b0;
          end else if (phase_r == pbrg_pkg::PH_BASE) begin
            divn_r <= meas_ok;
          end else if (phase_r == pbrg_pkg::PH_PROBE) begin
            divn_r <= meas_ok && bvalid_r;
          end else if (phase_r == pbrg_pkg::PH_BACK) begin
            if (el >= TIME_BITS'(pbrg_pkg::backoff_ms(bidx_r))) begin
              phase_r <= pbrg_pkg::PH_BASE; pstart_r <= now_r;
              ssum_r <= '0; lsum_r <= '0; cnt_r <= '0;
            end
          end
        end
      end
    end else if (cmd.decide) begin
      // sums are divided; take the phase decision
      if (divn_r) begin
        if (phase_r == pbrg_pkg::PH_BASE) begin
          bsrc_r <= RATE_BITS'(qa); blp_r <= RATE_BITS'(qb); bvalid_r <= 1'b1;
          phase_r <= grow ? pbrg_pkg::PH_PROBE : pbrg_pkg::PH_BASE;
        end else if (improved && held) begin
          acc_r <= acc1; bidx_r <= '0; phase_r <= pbrg_pkg::PH_BASE;
        end else begin
          phase_r <= pbrg_pkg::PH_BACK;
          if (bidx_r != 2'd3) bidx_r <= bidx_r + 2'd1;
        end
        pstart_r <= now_r; ssum_r <= '0; lsum_r <= '0; cnt_r <= '0;
        divn_r <= 1'b0;
      end
    end
  end

  // allowed level is formed combinationally from the state registers
  logic use_calc;
  assign use_calc = (cap != 4'd0) && (req_r != 4'd0) && !(therm_r >= 4'sd4);
  assign allowed_o  = use_calc ? allowed_calc : allowed_r;
  assign phase_o    = phase_r;
  assign blocked_o  = therm_r >= 4'sd4;
  assign accepted_o = acc_r;
endmodule

/* hdl/pbrg_ctrl.sv */
// controller sequencing one frame report through the datapath
`timescale 1ns / 1ps
module pbrg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_fire,
  input  pbrg_pkg::dp_sts_t sts,
  output pbrg_pkg::dp_cmd_t cmd_base,
  output logic              in_ready,
  output logic              out_valid
);
  pbrg_pkg::ctl_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbrg_pkg::ST_IDLE:   if (in_fire) state_nxt = pbrg_pkg::ST_EVAL;
      pbrg_pkg::ST_EVAL:   state_nxt = pbrg_pkg::ST_DIV;
      pbrg_pkg::ST_DIV: begin
        if (!sts.div_needed) state_nxt = pbrg_pkg::ST_OUT;
        else if (sts.div_done) state_nxt = pbrg_pkg::ST_DECIDE;
      end
      pbrg_pkg::ST_DECIDE: state_nxt = pbrg_pkg::ST_OUT;
      pbrg_pkg::ST_OUT:    if (out_fire) state_nxt = pbrg_pkg::ST_IDLE;
      default:             state_nxt = pbrg_pkg::ST_IDLE;
    endcase
  end

  logic started_r;

  // outputs
  always_comb begin
    cmd_base = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      pbrg_pkg::ST_IDLE:   begin in_ready = 1'b1; cmd_base.load = in_fire; end
      pbrg_pkg::ST_EVAL:   cmd_base.eval = 1'b1;
      pbrg_pkg::ST_DIV:    cmd_base.div_start = sts.div_needed && !started_r;
      pbrg_pkg::ST_DECIDE: cmd_base.decide = 1'b1;
      pbrg_pkg::ST_OUT:    out_valid = 1'b1;
      default:             cmd_base = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbrg_pkg::ST_IDLE; started_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      started_r <= (state_r == pbrg_pkg::ST_DIV);
    end
  end
endmodule

/* hdl/probe_backoff_rate_governor.sv */
// top level of the probe and backoff rate governor
`timescale 1ns / 1ps
// Usage:
// One frame report enters on the in_ stream; one result leaves on the out_ stream.
// in_tdata  : requested_level[3:0], source_rate, loop_rate, time_ms (low bits up)
// in_tuser  : thermal_status, 4 bit signed
// out_tdata : allowed_level[3:0], phase_now[5:4], thermal_blocked[6],
//             accepted_level[10:7]
// cfg_ channel writes max_generations; cfg_ready is high only while the block is
// idle, and a waiting write holds in_tready low so it goes first.
// From the input transaction the controller steps through its eval and div
// states to out_tvalid when no average is taken, and through a decide state
// after the div state when the serial divider forms the two averages. One
// report is in flight at a time; the divider loop sets the worst-case rate.
// Reset (rst_n low, synchronous) returns to baseline with empty sums, no
// thermal sample and a ceiling of zero.
// A stalled receiver holds the result in the datapath registers; in_tready
// stays low until that transaction completes.
module probe_backoff_rate_governor #(
  parameter int LEVEL_LIMIT = 8,
  parameter int RATE_BITS   = 16,
  parameter int TIME_BITS   = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // requested_level, source_rate, loop_rate, time_ms
  input  logic [((4+2*RATE_BITS+TIME_BITS+7)/8)*8-1:0] in_tdata,
  // thermal_status
  input  logic [3:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // allowed_level, phase_now, thermal_blocked, accepted_level
  output logic [15:0]                       out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [3:0]                        cfg_data
);
  localparam int SRC_LO = 4;
  localparam int LP_LO  = 4 + RATE_BITS;
  localparam int T_LO   = 4 + 2*RATE_BITS;

  pbrg_pkg::dp_cmd_t cmd, cmd_base;
  pbrg_pkg::dp_sts_t sts;
  logic in_fire, out_fire;
  logic ctl_ready;
  logic [3:0] allowed, accepted;
  logic [1:0] phase;
  logic blocked;

  // a waiting configuration write takes the idle slot first
  assign in_tready = ctl_ready && !cfg_valid;
  assign cfg_ready = ctl_ready;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // configuration write joins the controller commands
  always_comb begin
    cmd = cmd_base;
    cmd.cfg_write = cfg_valid && cfg_ready;
  end

  pbrg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd_base(cmd_base), .in_ready(ctl_ready), .out_valid(out_tvalid)
  );

  pbrg_datapath #(
    .LEVEL_LIMIT(LEVEL_LIMIT), .RATE_BITS(RATE_BITS),
    .TIME_BITS(TIME_BITS), .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cfg_value(cfg_data),
    .req_in(in_tdata[3:0]),
    .src_in(in_tdata[SRC_LO +: RATE_BITS]),
    .lp_in(in_tdata[LP_LO +: RATE_BITS]),
    .now_in(in_tdata[T_LO +: TIME_BITS]),
    .ts_in(in_tuser),
    .allowed_o(allowed), .phase_o(phase), .blocked_o(blocked), .accepted_o(accepted)
  );

  assign out_tdata = {5'd0, accepted, blocked, phase, allowed};

  // no input taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input ready while result pending");
  // accepted level never exceeds the limit
  a_acc_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:7] <= 4'(LEVEL_LIMIT))) else $error("accepted above limit");
  // allowed never exceeds accepted plus one
  a_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[3:0]} <= {1'b0, out_tdata[10:7]} + 5'd1))
    else $error("allowed above accepted plus one");
endmodule
